// ===== rtl/core/mpq_pkg.sv =====
// Shared types and codes for the min priority queue unit.
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

    // Operation carried in the input beat's tuser
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic    push;        // append entry, emit OK result
        logic    reject;      // emit error result, state untouched
        t_status rej_code;
        logic    scan_start;  // seed min search with entry 0
        logic    scan_step;   // compare one more entry
        logic    commit;      // emit minimum, close the gap
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic one_left;
        logic scan_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/core/mpq_datapath.sv =====
// Entry storage, sequential minimum search, compaction and result register.
`timescale 1ns / 1ps
`default_nettype none

module mpq_datapath #(
    parameter int DEPTH     = 8,
    parameter int PRIO_BITS = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  mpq_pkg::t_dp_cmd                 i_cmd,
    output mpq_pkg::t_dp_stat                o_stat,
    input  wire signed [31:0]                i_value,
    input  wire [PRIO_BITS-1:0]              i_prio,
    output mpq_pkg::t_status                 o_status,
    output logic signed [31:0]               o_value,
    output logic [PRIO_BITS-1:0]             o_prio,
    output logic [$clog2(DEPTH+1)-1:0]       o_occupancy
);
    import mpq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0]    r_val  [DEPTH];
    logic [PRIO_BITS-1:0]  r_prio [DEPTH];
    logic [CW-1:0]         r_count;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_best;
    logic [PRIO_BITS-1:0]  r_best_prio;

    t_status               r_status;
    logic signed [31:0]    r_out_value;
    logic [PRIO_BITS-1:0]  r_out_prio;
    logic [CW-1:0]         r_out_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.commit) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_val[r_count[IW-1:0]]  <= i_value;
            r_prio[r_count[IW-1:0]] <= i_prio;
        end else if (i_cmd.commit) begin
            // every entry above the removed one moves down a slot
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (IW'(i) >= r_best) begin
                    r_val[i]  <= r_val[i + 1];
                    r_prio[i] <= r_prio[i + 1];
                end
            end
        end
    end

    // strict less-than keeps the earliest entry on a tie
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_idx       <= IW'(1);
            r_best      <= '0;
            r_best_prio <= r_prio[0];
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + IW'(1);
            if (r_prio[r_idx] < r_best_prio) begin
                r_best      <= r_idx;
                r_best_prio <= r_prio[r_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_status    <= STAT_OK;
            r_out_value <= '0;
            r_out_prio  <= '0;
            r_out_occ   <= r_count + CW'(1);
        end else if (i_cmd.reject) begin
            r_status    <= i_cmd.rej_code;
            r_out_value <= '0;
            r_out_prio  <= '0;
            r_out_occ   <= r_count;
        end else if (i_cmd.commit) begin
            r_status    <= STAT_OK;
            r_out_value <= r_val[r_best];
            r_out_prio  <= r_best_prio;
            r_out_occ   <= r_count - CW'(1);
        end
    end

    always_comb begin
        o_stat.full      = (r_count == CW'(DEPTH));
        o_stat.empty     = (r_count == '0);
        o_stat.one_left  = (r_count == CW'(1));
        o_stat.scan_last = ((CW'(r_idx) + CW'(1)) == r_count);
    end

    assign o_status    = r_status;
    assign o_value     = r_out_value;
    assign o_prio      = r_out_prio;
    assign o_occupancy = r_out_occ;

endmodule

`default_nettype wire

// ===== rtl/core/mpq_ctrl.sv =====
// Operation sequencer and result-beat valid for the min priority queue.
`timescale 1ns / 1ps
`default_nettype none

module mpq_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_valid,
    output logic               o_s_ready,
    input  wire                i_mode,
    output logic               o_m_valid,
    input  wire                i_m_ready,
    output mpq_pkg::t_dp_cmd   o_cmd,
    input  mpq_pkg::t_dp_stat  i_stat
);
    import mpq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result slot is free or draining at accept, so a dequeue can always land its beat
    always_comb begin
        o_s_ready = (r_state == ST_IDLE) && (!r_out_valid || i_m_ready);
        w_accept  = i_s_valid && o_s_ready;
        n_state   = r_state;
        o_cmd     = '0;
        o_cmd.rej_code = STAT_OK;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_mode == MODE_ENQ) begin
                        if (i_stat.full) begin
                            o_cmd.reject   = 1'b1;
                            o_cmd.rej_code = STAT_OVERFLOW;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end else if (i_stat.empty) begin
                        o_cmd.reject   = 1'b1;
                        o_cmd.rej_code = STAT_UNDERFLOW;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state = i_stat.one_left ? ST_SHIFT : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        w_emit = o_cmd.push || o_cmd.reject || o_cmd.commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/core/min_priority_queue_unit.sv =====
// Top level: bounded min priority queue with stream ports.
// Enqueue and rejected operations: result beat in the cycle after accept.
// Dequeue: the result beat follows the priority scan, which compares one stored
//   entry per cycle, and the shift that removes the minimum and closes the gap.
// A new beat is taken once the unit is idle and its result slot is free or draining.
// Reset (synchronous, active low) empties the queue and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module min_priority_queue_unit #(
    parameter int DEPTH     = 8,
    parameter int PRIO_BITS = 8
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_s_tvalid,
    output logic o_s_tready,
    // [31:0] item_value, [32 +: PRIO_BITS] prio_in, zero padded to bytes
    input  wire  [((32 + PRIO_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // [0] mode
    input  wire  i_s_tuser,
    output logic o_m_tvalid,
    input  wire  i_m_tready,
    // [1:0] status, [33:2] out_value, then out_prio (PRIO_BITS), then occupancy,
    // zero padded to bytes
    output logic [((34 + PRIO_BITS + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] o_m_tdata
);
    import mpq_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = ((34 + PRIO_BITS + CW + 7) / 8) * 8;

    t_dp_cmd              w_cmd;
    t_dp_stat             w_stat;
    t_status              w_status;
    logic signed [31:0]   w_value;
    logic [PRIO_BITS-1:0] w_prio;
    logic [CW-1:0]        w_occ;

    mpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .o_s_ready (o_s_tready),
        .i_mode    (i_s_tuser),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .o_cmd     (w_cmd),
        .i_stat    (w_stat)
    );

    mpq_datapath #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_value     (i_s_tdata[31:0]),
        .i_prio      (i_s_tdata[32 +: PRIO_BITS]),
        .o_status    (w_status),
        .o_value     (w_value),
        .o_prio      (w_prio),
        .o_occupancy (w_occ)
    );

    assign o_m_tdata = OUT_W'({w_occ, w_prio, w_value, w_status});

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_occ <= CW'(DEPTH)))
        else $error("occupancy above depth");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_status == STAT_UNDERFLOW)) |->
            ((w_occ == '0) && (w_value == '0) && (w_prio == '0)))
        else $error("underflow result on a non-empty queue");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_status == STAT_OVERFLOW)) |-> (w_occ == CW'(DEPTH)))
        else $error("overflow result on a queue that is not full");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_cmd.push, w_cmd.reject, w_cmd.scan_start,
                    w_cmd.scan_step, w_cmd.commit}) <= 1)
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== tb/tb_min_priority_queue_unit.sv =====
// Self-checking testbench for the min priority queue unit.
`timescale 1ns / 1ps
`default_nettype none

module tb_min_priority_queue_unit;
    import mpq_pkg::*;

    localparam int QDEPTH     = 8;
    localparam int QPRIO_BITS = 8;
    localparam int IN_W       = ((32 + QPRIO_BITS + 7) / 8) * 8;
    localparam int OCC_W      = $clog2(QDEPTH + 1);
    localparam int OUT_W      = ((34 + QPRIO_BITS + OCC_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_PER_PHASE = 250;

    typedef struct packed {
        t_status              status;
        logic [31:0]          value;
        logic [QPRIO_BITS-1:0] prio;
        logic [OCC_W-1:0]     occupancy;
    } t_queue_result;

    // Holds its own copy of the queue contents and the results still owed.
    class queue_predictor;
        logic [31:0]           ent_value[$];
        logic [QPRIO_BITS-1:0] ent_prio[$];
        t_queue_result         owed_results[$];
        int errors, checked;
        int n_enq, n_deq, n_overflow, n_underflow, peak_fill;

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
        endfunction

        function void note_op(logic mode, logic [31:0] value, logic [QPRIO_BITS-1:0] prio);
            t_queue_result r;
            int best;
            r = '0;
            if (mode == MODE_ENQ) begin
                if (ent_value.size() >= QDEPTH) begin
                    r.status = STAT_OVERFLOW;
                    n_overflow++;
                end else begin
                    ent_value.push_back(value);
                    ent_prio.push_back(prio);
                    r.status = STAT_OK;
                    n_enq++;
                end
            end else if (ent_value.size() == 0) begin
                r.status = STAT_UNDERFLOW;
                n_underflow++;
            end else begin
                // earliest entry wins on equal priority
                best = 0;
                for (int i = 1; i < ent_prio.size(); i++)
                    if (ent_prio[i] < ent_prio[best]) best = i;
                r.status = STAT_OK;
                r.value  = ent_value[best];
                r.prio   = ent_prio[best];
                ent_value.delete(best);
                ent_prio.delete(best);
                n_deq++;
            end
            r.occupancy = OCC_W'(ent_value.size());
            if (ent_value.size() > peak_fill) peak_fill = ent_value.size();
            owed_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] beat);
            t_queue_result want, got;
            got.status    = t_status'(beat[1:0]);
            got.value     = beat[33:2];
            got.prio      = beat[34 +: QPRIO_BITS];
            got.occupancy = beat[34 + QPRIO_BITS +: OCC_W];
            checked++;
            if (owed_results.size() == 0) begin
                report($sformatf("unexpected result beat %h", beat));
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status exp %0d got %0d", want.status, got.status));
            if (got.value !== want.value)
                report($sformatf("value exp %h got %h", want.value, got.value));
            if (got.prio !== want.prio)
                report($sformatf("prio exp %0d got %0d", want.prio, got.prio));
            if (got.occupancy !== want.occupancy)
                report($sformatf("occupancy exp %0d got %0d", want.occupancy, got.occupancy));
        endfunction

        function int owed();
            return owed_results.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_s_tvalid;
    logic o_s_tready;
    logic [IN_W-1:0] i_s_tdata;   // [31:0] item_value, [39:32] prio_in
    logic i_s_tuser;              // [0] mode
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;  // [1:0] status, [33:2] out_value, [41:34] out_prio,
                                  // [45:42] occupancy

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int quiet_cycles  = 0;
    queue_predictor model = new();

    min_priority_queue_unit #(
        .DEPTH     (QDEPTH),
        .PRIO_BITS (QPRIO_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: check accepted beats, stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) model.check_result(o_m_tdata);
        i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_op(input logic mode, input logic [31:0] value,
                           input logic [QPRIO_BITS-1:0] prio);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {prio, value};
        do @(posedge i_clk); while (!o_s_tready);
        model.note_op(mode, value, prio);
    endtask

    // Dequeue with junk in the ignored data fields.
    task automatic send_deq();
        send_op(MODE_DEQ, $urandom, QPRIO_BITS'($urandom_range(0, 255)));
    endtask

    initial begin
        int enq_bias;
        logic [31:0] v;
        logic [QPRIO_BITS-1:0] p;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= MODE_ENQ;
        i_s_tdata  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, single entry, ties, extremes, full
        send_deq();
        send_op(MODE_ENQ, 32'h7FFF_FFFF, 8'd255);
        send_deq();
        send_deq();
        send_op(MODE_ENQ, 32'h8000_0000, 8'd0);
        send_op(MODE_ENQ, 32'hFFFF_FFFF, 8'd255);
        send_op(MODE_ENQ, 32'h0000_0000, 8'd7);
        send_op(MODE_ENQ, 32'h7FFF_FFFF, 8'd7);
        send_op(MODE_ENQ, 32'h1234_5678, 8'd0);
        send_op(MODE_ENQ, 32'hA5A5_A5A5, 8'd128);
        send_op(MODE_ENQ, 32'h5A5A_5A5A, 8'd1);
        send_op(MODE_ENQ, 32'hDEAD_BEEF, 8'd7);
        send_op(MODE_ENQ, 32'h0BAD_F00D, 8'd0);   // full: rejected
        send_op(MODE_DEQ, 32'hFFFF_FFFF, 8'hFF);
        send_op(MODE_DEQ, 32'h0000_0000, 8'h00);
        repeat (6) send_deq();
        send_deq();                                // empty again

        // random: enqueue bias swings so the queue sweeps between empty and full
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
                default: begin src_idle_pct = 14; sink_stall_pct = 14; end
            endcase
            enq_bias = 50;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (n % 20 == 0) enq_bias = ($urandom_range(0, 1) != 0) ? 80 : 20;
                if ($urandom_range(0, 99) < enq_bias) begin
                    case ($urandom_range(0, 7))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7FFF_FFFF;
                        2: v = 32'hFFFF_FFFF;
                        3: v = 32'h0000_0000;
                        default: v = $urandom;
                    endcase
                    case ($urandom_range(0, 5))
                        0, 1, 2: p = QPRIO_BITS'($urandom_range(0, 3));   // many ties
                        3: p = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                        default: p = QPRIO_BITS'($urandom_range(0, 255));
                    endcase
                    send_op(MODE_ENQ, v, p);
                end else begin
                    send_deq();
                end
            end
        end

        i_s_tvalid <= 1'b0;
        while (model.owed() != 0) @(posedge i_clk);
        repeat (QDEPTH + 4) @(posedge i_clk);
        model.errors += model.owed();

        $display("covered %0d result beats: %0d enqueues, %0d dequeues, %0d overflows,",
                 model.checked, model.n_enq, model.n_deq, model.n_overflow);
        $display("%0d underflows, peak fill %0d, over four idle/stall phases",
                 model.n_underflow, model.peak_fill);
        if (model.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("mismatches: %0d", model.errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
